// File: hw/rtl/cc20_pkg.sv
// Shared types, constants and codes for the ChaCha20 stream cipher core.
`default_nettype none

package cc20_pkg;

    typedef logic [31:0] word_t;

    // "expand 32-byte k" constant words.
    localparam word_t SIGMA0 = 32'h6170_7865;
    localparam word_t SIGMA1 = 32'h3320_646e;
    localparam word_t SIGMA2 = 32'h7962_2d32;
    localparam word_t SIGMA3 = 32'h6b20_6574;

    localparam int DOUBLE_ROUNDS = 10;

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY0      = 3'd0;
    localparam logic [2:0] REG_KEY1      = 3'd1;
    localparam logic [2:0] REG_KEY2      = 3'd2;
    localparam logic [2:0] REG_KEY3      = 3'd3;
    localparam logic [2:0] REG_NONCE_LO  = 3'd4;
    localparam logic [2:0] REG_NONCE_HI  = 3'd5;
    localparam logic [2:0] REG_START_CTR = 3'd6;

    // Rotate amount selection for the quarter-round unit.
    typedef enum logic [1:0] {
        ROT_16 = 2'd0,
        ROT_12 = 2'd1,
        ROT_8  = 2'd2,
        ROT_7  = 2'd3
    } rot_sel_t;

    typedef enum logic [2:0] {
        GS_IDLE,
        GS_COL,
        GS_DIAG,
        GS_DIAGQ,
        GS_UNDIAG,
        GS_FEED
    } gen_state_t;

    typedef enum logic [0:0] {
        TS_IDLE,
        TS_GEN
    } top_state_t;

    // Commands from the byte handler to the block generator.
    typedef struct packed {
        logic start;
        logic shift;
    } gen_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/chacha20_stream_cipher_core.sv
// ChaCha20 stream cipher core: configuration, byte handshake and block control.
//
// Each item on the slave channel carries one message byte in s_tdata and a
// last-byte mark in s_tlast. Each item returns one byte on the master channel:
// the input byte XORed with the keystream byte at the current position.
// The user must write key, nonce and start counter through cfg_we / cfg_addr /
// cfg_wdata only while the core is idle; the core does not enforce this.
// They are sampled when a block is made. A byte that does not start a
// 64-byte block leaves on the output in the cycle after it is accepted, and
// the next byte can be taken in that same cycle if m_tready is high. A byte
// that starts a block (first byte of a message or every 64th byte) waits
// for the block generator: a load, ten double rounds on the shared
// quarter-round step unit and a feed-forward pass; no byte is taken in the
// meantime. A block of 64 bytes is dominated by its 320 quarter-round steps.
// Reset clears the counter, the block position and sets the next byte to
// start a message; the start counter resets to one, key and nonce to zero.
// While m_tready is low the result is held and s_tready stays low once the
// output register is full.
`default_nettype none

module chacha20_stream_cipher_core
    import cc20_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // data_byte[7:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // out_byte[7:0]
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [63:0] cfg_wdata
);

    logic [3:0][63:0] key_reg;
    logic [63:0]      nonce_lo_reg;
    word_t            nonce_hi_reg;
    word_t            start_ctr_reg;

    top_state_t state_reg, state_next;
    word_t      ctr_reg;
    logic [5:0] offset_reg;
    logic       fresh_reg;
    logic [7:0] data_reg;
    logic       m_valid_reg;
    logic [7:0] m_data_reg;

    logic       accept;
    logic       need_block;
    logic       out_free;
    logic       emit;
    logic [7:0] emit_src;
    word_t      blk_ctr;
    gen_cmd_t   cmd;
    logic       gen_busy;
    logic [7:0] ks_byte;

    cc20_block_gen u_gen (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .key      (key_reg),
        .nonce_lo (nonce_lo_reg),
        .nonce_hi (nonce_hi_reg),
        .ctr      (blk_ctr),
        .busy     (gen_busy),
        .ks_byte  (ks_byte)
    );

    assign out_free   = ~m_valid_reg | m_tready;
    assign accept     = s_tvalid & s_tready;
    assign need_block = fresh_reg | (offset_reg == 6'd0);
    assign blk_ctr    = fresh_reg ? start_ctr_reg : ctr_reg;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TS_IDLE:
            begin
                if (accept && need_block)
                    state_next = TS_GEN;
            end
            TS_GEN:
            begin
                if (!gen_busy && out_free)
                    state_next = TS_IDLE;
            end
            default:
                state_next = TS_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready  = 1'b0;
        emit      = 1'b0;
        emit_src  = s_tdata;
        cmd.start = 1'b0;
        case (state_reg)
            TS_IDLE:
            begin
                s_tready  = out_free;
                emit      = accept & ~need_block;
                cmd.start = accept & need_block;
            end
            TS_GEN:
            begin
                emit     = ~gen_busy & out_free;
                emit_src = data_reg;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
        cmd.shift = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= TS_IDLE;
            ctr_reg     <= '0;
            offset_reg  <= '0;
            fresh_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (need_block)
                    ctr_reg <= blk_ctr + 32'd1;
                offset_reg <= fresh_reg ? 6'd1 : offset_reg + 6'd1;
                fresh_reg  <= s_tlast;
            end
            if (emit)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            data_reg <= s_tdata;
        if (emit)
            m_data_reg <= emit_src ^ ks_byte;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= '0;
            nonce_lo_reg  <= '0;
            nonce_hi_reg  <= '0;
            start_ctr_reg <= 32'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_KEY0:      key_reg[0]    <= cfg_wdata;
                REG_KEY1:      key_reg[1]    <= cfg_wdata;
                REG_KEY2:      key_reg[2]    <= cfg_wdata;
                REG_KEY3:      key_reg[3]    <= cfg_wdata;
                REG_NONCE_LO:  nonce_lo_reg  <= cfg_wdata;
                REG_NONCE_HI:  nonce_hi_reg  <= cfg_wdata[31:0];
                REG_START_CTR: start_ctr_reg <= cfg_wdata[31:0];
                default:       ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cc20_qr_unit.sv
// Shared add / xor / rotate unit: one quarter-round step per use.
`default_nettype none

module cc20_qr_unit
    import cc20_pkg::*;
(
    input  wire word_t    p,
    input  wire word_t    q,
    input  wire word_t    r,
    input  wire rot_sel_t rot,
    output word_t         sum,
    output word_t         mix
);

    word_t x;

    assign sum = p + q;
    assign x   = r ^ sum;

    always_comb
    begin
        case (rot)
            ROT_16:  mix = {x[15:0], x[31:16]};
            ROT_12:  mix = {x[19:0], x[31:20]};
            ROT_8:   mix = {x[23:0], x[31:24]};
            ROT_7:   mix = {x[24:0], x[31:25]};
            default: mix = x;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/cc20_block_gen.sv
// Keystream block generator: state words, round sequencer and byte readout.
`default_nettype none

module cc20_block_gen
    import cc20_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gen_cmd_t          cmd,
    input  wire logic [3:0][63:0]  key,
    input  wire logic [63:0]       nonce_lo,
    input  wire word_t             nonce_hi,
    input  wire word_t             ctr,
    output logic                   busy,
    output logic [7:0]             ks_byte
);

    gen_state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [3:0] dr_reg, dr_next;

    // Working state laid out as four rows of four words, word index row*4+col.
    word_t w_reg [16];
    word_t w_next [16];
    word_t init_reg [16];
    word_t init_next [16];
    word_t load_w [16];
    word_t tmp_w [16];

    word_t    u_p, u_q, u_r, u_sum, u_mix;
    rot_sel_t u_rot;
    logic     step_even;

    cc20_qr_unit u_qr (
        .p   (u_p),
        .q   (u_q),
        .r   (u_r),
        .rot (u_rot),
        .sum (u_sum),
        .mix (u_mix)
    );

    assign step_even = ~cnt_reg[0];
    assign ks_byte   = w_reg[0][7:0];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            load_w[4 + 2 * i] = key[i][31:0];
            load_w[5 + 2 * i] = key[i][63:32];
        end
        load_w[0]  = SIGMA0;
        load_w[1]  = SIGMA1;
        load_w[2]  = SIGMA2;
        load_w[3]  = SIGMA3;
        load_w[12] = ctr;
        load_w[13] = nonce_lo[31:0];
        load_w[14] = nonce_lo[63:32];
        load_w[15] = nonce_hi;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            GS_IDLE:
            begin
                if (cmd.start)
                    state_next = GS_COL;
            end
            GS_COL:
            begin
                if (cnt_reg == 4'd15)
                    state_next = GS_DIAG;
            end
            GS_DIAG:
                state_next = GS_DIAGQ;
            GS_DIAGQ:
            begin
                if (cnt_reg == 4'd15)
                    state_next = GS_UNDIAG;
            end
            GS_UNDIAG:
            begin
                if (dr_reg == 4'(DOUBLE_ROUNDS - 1))
                    state_next = GS_FEED;
                else
                    state_next = GS_COL;
            end
            GS_FEED:
            begin
                if (cnt_reg == 4'd15)
                    state_next = GS_IDLE;
            end
            default:
                state_next = GS_IDLE;
        endcase
    end

    // Outputs and shared unit operand selection
    always_comb
    begin
        busy  = (state_reg != GS_IDLE);
        u_p   = step_even ? w_reg[0] : w_reg[8];
        u_q   = step_even ? w_reg[4] : w_reg[12];
        u_r   = step_even ? w_reg[12] : w_reg[4];
        u_rot = rot_sel_t'(cnt_reg[1:0]);
        if (state_reg == GS_FEED)
        begin
            u_p = w_reg[0];
            u_q = init_reg[0];
        end
    end

    // Datapath
    always_comb
    begin
        cnt_next = cnt_reg;
        dr_next  = dr_reg;
        for (int i = 0; i < 16; i++)
        begin
            w_next[i]    = w_reg[i];
            init_next[i] = init_reg[i];
            tmp_w[i]     = w_reg[i];
        end

        // Column zero after one quarter-round step.
        if (step_even)
        begin
            tmp_w[0]  = u_sum;
            tmp_w[12] = u_mix;
        end
        else
        begin
            tmp_w[8]  = u_sum;
            tmp_w[4]  = u_mix;
        end

        case (state_reg)
            GS_IDLE:
            begin
                cnt_next = '0;
                dr_next  = '0;
                if (cmd.start)
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        w_next[i]    = load_w[i];
                        init_next[i] = load_w[i];
                    end
                end
                else if (cmd.shift)
                begin
                    // Next keystream byte moves into the low byte of word zero.
                    for (int i = 0; i < 15; i++)
                        w_next[i] = {w_reg[i + 1][7:0], w_reg[i][31:8]};
                    w_next[15] = {8'h00, w_reg[15][31:8]};
                end
            end
            GS_COL, GS_DIAGQ:
            begin
                cnt_next = cnt_reg + 4'd1;
                // After a full quarter round, every row turns left by one word
                // so that the next quarter round sits in column zero.
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        w_next[r * 4 + c] = (cnt_reg[1:0] == 2'd3) ?
                                            tmp_w[r * 4 + ((c + 1) % 4)] :
                                            tmp_w[r * 4 + c];
            end
            GS_DIAG:
            begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        w_next[r * 4 + c] = w_reg[r * 4 + ((c + r) % 4)];
            end
            GS_UNDIAG:
            begin
                dr_next = dr_reg + 4'd1;
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        w_next[r * 4 + c] = w_reg[r * 4 + ((c + 4 - r) % 4)];
            end
            GS_FEED:
            begin
                // Both rings turn once per cycle; after a full pass through GS_FEED every
                // word has had its input word added and is back in place.
                cnt_next = cnt_reg + 4'd1;
                for (int i = 0; i < 15; i++)
                begin
                    w_next[i]    = w_reg[i + 1];
                    init_next[i] = init_reg[i + 1];
                end
                w_next[15]    = u_sum;
                init_next[15] = init_reg[0];
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= GS_IDLE;
            cnt_reg   <= '0;
            dr_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dr_reg    <= dr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            w_reg[i]    <= w_next[i];
            init_reg[i] <= init_next[i];
        end
    end

endmodule

`default_nettype wire
